// ===== design/fdc_pkg.sv =====
// Shared constants for the factorial divisor counter.
package fdc_pkg;
	localparam int unsigned MaxN = 65536;
	localparam int FLAG_AW = $clog2(MaxN);
	localparam int N_W = 16;
	localparam int OUT_W = 30;
	localparam logic [OUT_W-1:0] MODULUS = 30'd1000000007;

	// divider request/response between sequencer and shared divider
	typedef struct packed {
		logic            start;
		logic [N_W-1:0]  dividend;
		logic [N_W:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [N_W-1:0]  quotient;
	} div_rsp_t;
endpackage

// ===== design/fdc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module fdc_div import fdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CW = $clog2(N_W + 1);
	logic [N_W-1:0] quo_q;
	logic [N_W:0]   rem_q, den_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [N_W+1:0] trial;

	assign trial = {rem_q, quo_q[N_W-1]} - {1'b0, den_q};

	// step counter, busy flag and done strobe for the shift-subtract steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[N_W+1]) begin
				rem_q <= trial[N_W:0];
				quo_q <= {quo_q[N_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[N_W-1:0], quo_q[N_W-1]};
				quo_q <= {quo_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== design/factorial_divisor_count.sv =====
// Top level: sieve, Legendre exponent sequencer and modular product.
// channel | dir | tdata fields (lsb up)
// s_axis  | in  | n_value[15:0]
// m_axis  | out | divisor_count[29:0], zero padded to 32
// After reset a sieve sweeps the 65536-entry prime bitmap: an initializing pass that marks
// every entry from 2 up as prime, then crosses off the multiples of each prime, s_tready low throughout.
// Per query: each candidate p <= n is read from the bitmap; each prime gets its Legendre exponent
// from the shared divider, one division per power of p up to n, then a shift-add modular
// multiply of the product by (exponent + 1); n below 2 goes straight out.
// One query at a time; s_tready returns after m_axis beat is taken.
module factorial_divisor_count import fdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // n_value[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // divisor_count[29:0], pad
);
	localparam logic [3:0] ST_CLR = 4'd0, ST_SV_I = 4'd1, ST_SV_RD = 4'd2,
		ST_SV_J = 4'd3, ST_IDLE = 4'd4, ST_P_RD = 4'd5, ST_P_CHK = 4'd6,
		ST_DIV = 4'd7, ST_POW = 4'd8, ST_MUL = 4'd9, ST_OUT = 4'd10;
	localparam int AW = FLAG_AW;

	logic [3:0]     st_q;
	logic           mem [MaxN];
	logic           rd_q;
	logic [AW:0]    i_q, j_q;
	logic [N_W-1:0] n_q;
	logic [N_W:0]   p_q, pw_q;
	logic [N_W:0]   expo_q;
	logic [OUT_W-1:0] ans_q, acc_q;
	logic [N_W:0]   mb_q;
	logic [4:0]     mcnt_q;
	logic           we;
	logic [AW-1:0]  wa, ra;
	logic           wd;
	div_req_t       dreq;
	div_rsp_t       drsp;
	logic [2*N_W+1:0] pwp;
	logic [OUT_W:0] acc2, addv;

	fdc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign pwp = pw_q * p_q;
	// shift-add modular multiply step: acc = 2*acc mod M, then + ans mod M when the multiplier bit is set
	logic [OUT_W:0] dbl;
	logic [OUT_W-1:0] dblr;
	assign dbl  = {acc_q, 1'b0};
	assign dblr = (dbl >= {1'b0, MODULUS}) ? OUT_W'(dbl - {1'b0, MODULUS}) : dbl[OUT_W-1:0];
	assign addv = {1'b0, dblr} + {1'b0, ans_q};
	assign acc2 = mb_q[mcnt_q] ? ((addv >= {1'b0, MODULUS}) ? addv - {1'b0, MODULUS} : addv)
		: {1'b0, dblr};

	// bitmap port control
	always_comb begin
		we = 1'b0; wa = i_q[AW-1:0]; wd = 1'b1; ra = i_q[AW-1:0];
		unique case (st_q)
			ST_CLR:  begin we = 1'b1; wd = (i_q > (AW+1)'(1)); end
			ST_SV_J: begin we = 1'b1; wa = j_q[AW-1:0]; wd = 1'b0; end
			ST_P_RD: ra = p_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	assign dreq.start    = (st_q == ST_P_CHK && rd_q) || (st_q == ST_POW && !(pwp > 34'(n_q)));
	assign dreq.dividend = n_q;
	assign dreq.divisor  = (st_q == ST_POW) ? pwp[N_W:0] : p_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			i_q  <= '0;
		end else begin
			unique case (st_q)
				ST_CLR: begin
					i_q <= i_q + 1'b1;
					if (i_q == (AW+1)'(MaxN - 1)) begin st_q <= ST_SV_I; i_q <= (AW+1)'(2); end
				end
				ST_SV_I: st_q <= (i_q * i_q >= (2*AW+2)'(MaxN)) ? ST_IDLE : ST_SV_RD;
				ST_SV_RD: begin
					j_q <= (AW+1)'(i_q * i_q);
					if (rd_q) st_q <= ST_SV_J;
					else begin i_q <= i_q + 1'b1; st_q <= ST_SV_I; end
				end
				ST_SV_J: begin
					if (j_q + i_q >= (AW+1)'(MaxN)) begin
						i_q <= i_q + 1'b1; st_q <= ST_SV_I;
					end
					j_q <= j_q + i_q;
				end
				ST_IDLE: if (s_tvalid) begin
					n_q <= s_tdata; ans_q <= OUT_W'(1); p_q <= (N_W+1)'(2);
					st_q <= (s_tdata < 16'd2) ? ST_OUT : ST_P_RD;
				end
				ST_P_RD: st_q <= ST_P_CHK;
				ST_P_CHK: begin
					if (rd_q) begin expo_q <= '0; pw_q <= p_q; st_q <= ST_DIV; end
					else if (p_q >= {1'b0, n_q}) st_q <= ST_OUT;
					else begin p_q <= p_q + 1'b1; st_q <= ST_P_RD; end
				end
				ST_DIV: if (drsp.done) begin
					expo_q <= expo_q + {1'b0, drsp.quotient};
					st_q <= ST_POW;
				end
				ST_POW: begin
					if (pwp > 34'(n_q)) begin
						mb_q <= expo_q + 1'b1; mcnt_q <= 5'(N_W); acc_q <= '0;
						st_q <= ST_MUL;
					end else begin pw_q <= pwp[N_W:0]; st_q <= ST_DIV; end
				end
				ST_MUL: begin
					acc_q <= acc2[OUT_W-1:0];
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == 5'd0) begin
						ans_q <= acc2[OUT_W-1:0];
						if (p_q >= {1'b0, n_q}) st_q <= ST_OUT;
						else begin p_q <= p_q + 1'b1; st_q <= ST_P_RD; end
					end
				end
				ST_OUT: if (m_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_OUT);
	assign m_tdata  = {2'b00, ans_q};

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output both open");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ans_q < MODULUS) else $error("result not reduced");
endmodule

// ===== bench/tb_factorial_divisor_count.sv =====
// Testbench for factorial_divisor_count: directed table plus random queries against a predictor.
module tb_factorial_divisor_count import fdc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned DIV_MOD = 64'd1000000007;
	localparam int NUM_DIRECTED = 12;
	localparam int NUM_RANDOM = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;   // n_value[15:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;        // divisor_count[29:0], pad

	// prime bitmap kept by the bench
	bit prime_map [0:MaxN-1];
	// divisor counts still owed by the block, oldest first
	logic [OUT_W-1:0] pending_counts[$];
	int queries_taken = 0;
	int failures = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	// directed table: n and the count, or -1 where the predictor decides
	int unsigned dir_n [NUM_DIRECTED] = '{0, 1, 2, 3, 4, 5, 10, 65535, 65534, 256, 1000, 32768};
	longint dir_count [NUM_DIRECTED] = '{1, 1, 2, 4, 8, 16, -1, -1, -1, -1, -1, -1};

	factorial_divisor_count i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Legendre exponent per prime, product of (exponent + 1) mod 1e9+7
	function automatic logic [OUT_W-1:0] divisors_of_factorial(input logic [15:0] n);
		longint unsigned prod, expo, pw, nn;
		prod = 1;
		nn = n;
		for (longint unsigned p = 2; p <= nn && p < MaxN; p++) begin
			if (prime_map[p]) begin
				expo = 0;
				pw = p;
				while (pw <= nn) begin
					expo += nn / pw;
					pw *= p;
				end
				prod = (prod * ((expo + 1) % DIV_MOD)) % DIV_MOD;
			end
		end
		return prod[OUT_W-1:0];
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// accept monitor and result check
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %0d", $time, m_tdata);
				failures++;
			end else begin
				logic [OUT_W-1:0] want;
				want = pending_counts.pop_front();
				if (m_tdata[OUT_W-1:0] !== want || m_tdata[31:OUT_W] !== '0) begin
					$display("%0t: divisor_count mismatch, expected %0d, actual %0d",
						$time, want, m_tdata);
					failures++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			pending_counts.push_back(divisors_of_factorial(s_tdata));
			queries_taken++;
		end
	end

	// one query, with sender idle cycles ahead of it
	task automatic send_query(input logic [15:0] n);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= n;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every owed result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_counts.size() != 0) @(posedge clk);
	endtask

	// mostly small n to keep per-query time low, a few up to the full range
	function automatic logic [15:0] pick_n();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 85) return 16'($urandom_range(255));
		if (r < 97) return 16'($urandom_range(4095));
		return 16'($urandom);
	endfunction

	initial begin
		int unsigned total;
		// sieve over the table
		for (int i = 0; i < MaxN; i++) prime_map[i] = (i >= 2);
		for (int i = 2; i * i < MaxN; i++) begin
			if (prime_map[i]) begin
				for (int j = i * i; j < MaxN; j += i) prime_map[j] = 1'b0;
			end
		end
		for (int k = 0; k < NUM_DIRECTED; k++) begin
			if (dir_count[k] >= 0 && divisors_of_factorial(16'(dir_n[k])) != dir_count[k]) begin
				$display("%0t: table entry %0d disagrees, expected %0d, actual %0d",
					$time, dir_n[k], dir_count[k], divisors_of_factorial(16'(dir_n[k])));
				failures++;
			end
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		for (int k = 0; k < NUM_DIRECTED; k++) send_query(16'(dir_n[k]));
		total = NUM_DIRECTED;

		// random part across idling phases
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 85; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 85; end
				default: begin src_idle_pct = 17; sink_stall_pct = 17; end
			endcase
			for (int k = 0; k < NUM_RANDOM / 4; k++) send_query(pick_n());
			total += NUM_RANDOM / 4;
		end
		s_tvalid <= 1'b0;

		while (queries_taken < total || pending_counts.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("PASS factorial_divisor_count");
		else
			$display("FAIL factorial_divisor_count");
		$finish;
	end

	// run limit
	initial begin
		#1500ms;
		$display("FAIL factorial_divisor_count");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/fdc_pkg.sv
design/fdc_div.sv
design/factorial_divisor_count.sv
bench/tb_factorial_divisor_count.sv
